// ===== design/gbn_pkg.sv =====
// Shared types for the go-back-n sender: command codes, controller states,
// and the command and status bundles between controller and datapath.
// No dependencies.
package gbn_pkg;

	typedef enum logic [1:0] {
		CMD_MSG  = 2'd0,
		CMD_ACK  = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECIDE = 7'b0000010,
		ST_ACK2   = 7'b0000100,
		ST_TIME   = 7'b0001000,
		ST_EXPIRE = 7'b0010000,
		ST_RD     = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	localparam int unsigned MSG_BYTES = 20;
	localparam int unsigned SUM_W     = 13;

	localparam logic CFG_WINDOW  = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	typedef struct packed {
		logic latch_in;
		logic msg_write;
		logic ack_update;
		logic tick;
		logic timer_stop;
		logic time_read;
		logic time_load;
		logic launch;
		logic single;
		logic retx_start;
		logic rd_issue;
		logic advance;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic ack_ok;
		logic base_eq_next;
		logic msg_go;
		logic launch_go;
		logic expire;
		logic win_empty;
		logic emit_last;
	} stat_t;

endpackage

// ===== design/go_back_n_sender_unit.sv =====
// Go-back-n sender top level. Each item is taken in ST_IDLE and decoded in ST_DECIDE;
// an accepted ack goes on through ST_ACK2, and through ST_TIME when it reloads the timer
// from the send-time memory, and a tick goes through ST_EXPIRE. Each packet sent takes
// one memory read (ST_RD) and an output state (ST_OUT) that waits out any output stall;
// no new item is taken until the burst is through. The single read port of the packet
// memory sets the burst rate. Reset is asynchronous, active low; the memories are not cleared.
module go_back_n_sender_unit
	import gbn_pkg::*;
#(
	parameter int BUFFER_DEPTH = 1024,
	parameter int WINDOW_MAX = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// payload_low, payload_mid, payload_high, ack_seq_field, ack_number, ack_checksum
	input  logic [223:0] s_axis_tdata,
	// cmd
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_seq, out_checksum, out_payload_low, out_payload_mid, out_payload_high
	output logic [191:0] m_axis_tdata,
	// is_retransmit
	output logic         m_axis_tuser,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);

	ctl_t  ctl;
	stat_t stat;

	assign cfg_ready = 1'b1;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	gbn_datapath #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.WINDOW_MAX  (WINDOW_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.in_cmd   (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_data (m_axis_tdata),
		.out_retx (m_axis_tuser),
		.out_last (m_axis_tlast)
	);

endmodule

// ===== design/gbn_scrub.sv =====
// Payload scrubber: clears every byte after the first zero byte and sums the
// remaining bytes as signed values. Depends on gbn_pkg.
module gbn_scrub
	import gbn_pkg::*;
(
	input  logic [8*MSG_BYTES-1:0] raw,
	output logic [8*MSG_BYTES-1:0] clean,
	output logic [SUM_W-1:0]       sum
);

	always_comb begin
		logic ended;
		logic [7:0] b;
		logic [SUM_W-1:0] pair [MSG_BYTES/2];
		logic [SUM_W-1:0] quad [MSG_BYTES/4];
		ended = 1'b0;
		clean = '0;
		for (int i = 0; i < MSG_BYTES; i++) begin
			b = raw[8*i +: 8];
			if (b == 8'd0)
				ended = 1'b1;
			if (ended)
				b = 8'd0;
			clean[8*i +: 8] = b;
		end
		for (int j = 0; j < MSG_BYTES/2; j++)
			pair[j] = {{(SUM_W-8){clean[16*j+7]}}, clean[16*j +: 8]}
				+ {{(SUM_W-8){clean[16*j+15]}}, clean[16*j+8 +: 8]};
		for (int k = 0; k < MSG_BYTES/4; k++)
			quad[k] = pair[2*k] + pair[2*k+1];
		sum = (quad[0] + quad[1]) + (quad[2] + quad[3]) + quad[4];
	end

endmodule

// ===== design/gbn_datapath.sv =====
// Datapath of the go-back-n sender: window counters, timer, packet and
// send-time memories, and the output packet. Depends on gbn_pkg, gbn_scrub.
module gbn_datapath
	import gbn_pkg::*;
#(
	parameter int BUFFER_DEPTH = 1024,
	parameter int WINDOW_MAX = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  ctl_t         ctl,
	output stat_t        stat,
	input  logic [1:0]   in_cmd,
	input  logic [223:0] in_data,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data,
	output logic [191:0] out_data,
	output logic         out_retx,
	output logic         out_last
);

	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
	localparam int LIM_W  = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
	localparam int PL_W   = 8 * MSG_BYTES;
	localparam int MEM_W  = PL_W + SUM_W;

	logic [5:0]  window_q;
	logic [15:0] timeout_q;
	cmd_t        cmd_q;
	logic [PL_W-1:0]  pl_q;
	logic [SUM_W-1:0] sum_q;
	logic [15:0] seqf_q, ackn_q;
	logic [31:0] cks_q;
	logic [CNT_W-1:0] base_q, next_q, stored_q, cur_q, end_q;
	logic        retx_q, running_q;
	logic [31:0] now_q, deadline_q, trd_q;
	logic [MEM_W-1:0] rd_q;
	logic [MEM_W-1:0] pmem [BUFFER_DEPTH];
	logic [31:0]      tmem [BUFFER_DEPTH];

	logic [PL_W-1:0]  clean;
	logic [SUM_W-1:0] sum;
	logic [WIN_W-1:0] win;
	logic [LIM_W-1:0] lim_w, lim_g;
	logic [CNT_W-1:0] lim;
	logic [31:0]      ack_sum;
	logic [31:0]      tdiff;
	logic             go;

	gbn_scrub u_scrub (
		.raw  (in_data[PL_W-1:0]),
		.clean(clean),
		.sum  (sum)
	);

	always_comb begin
		if (window_q == 6'd0)
			win = WIN_W'(1);
		else if (int'(window_q) > WINDOW_MAX)
			win = WIN_W'(WINDOW_MAX);
		else
			win = WIN_W'(window_q);
		lim_w = LIM_W'(base_q) + LIM_W'(win);
		lim_g = (lim_w > LIM_W'(stored_q)) ? LIM_W'(stored_q) : lim_w;
		ack_sum = {{(32-SUM_W){sum_q[SUM_W-1]}}, sum_q} + {{16{seqf_q[15]}}, seqf_q}
			+ {{16{ackn_q[15]}}, ackn_q};
		tdiff = now_q - deadline_q;
		stat.cmd = cmd_q;
		stat.full = (stored_q == CNT_W'(BUFFER_DEPTH));
		stat.ack_ok = (ack_sum == cks_q) && !ackn_q[15]
			&& (ackn_q >= 16'(base_q)) && (ackn_q < 16'(next_q));
		stat.base_eq_next = (base_q == next_q);
		stat.msg_go = (LIM_W'(next_q) < lim_w);
		stat.launch_go = (LIM_W'(next_q) < lim_g);
		stat.expire = running_q && !tdiff[31];
		stat.win_empty = (base_q >= next_q);
		stat.emit_last = ((cur_q + CNT_W'(1)) == end_q);
		go = ctl.single ? stat.msg_go : stat.launch_go;
		lim = ctl.single ? (next_q + CNT_W'(1)) : CNT_W'(lim_g);
	end

	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			pl_q   <= clean;
			sum_q  <= sum;
			seqf_q <= in_data[175:160];
			ackn_q <= in_data[191:176];
			cks_q  <= in_data[223:192];
		end
		if (ctl.msg_write)
			pmem[stored_q[ADDR_W-1:0]] <= {sum_q, pl_q};
		if (ctl.rd_issue) begin
			rd_q <= pmem[cur_q[ADDR_W-1:0]];
			tmem[cur_q[ADDR_W-1:0]] <= now_q;
		end
		if (ctl.time_read)
			trd_q <= tmem[base_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= 6'd8;
			timeout_q  <= 16'd20;
			cmd_q      <= CMD_NONE;
			base_q     <= '0;
			next_q     <= '0;
			stored_q   <= '0;
			cur_q      <= '0;
			end_q      <= '0;
			retx_q     <= 1'b0;
			running_q  <= 1'b0;
			now_q      <= '0;
			deadline_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TIMEOUT)
					timeout_q <= cfg_data;
				else
					window_q <= cfg_data[5:0];
			end
			if (ctl.latch_in)
				cmd_q <= cmd_t'(in_cmd);
			if (ctl.msg_write)
				stored_q <= stored_q + CNT_W'(1);
			if (ctl.ack_update)
				base_q <= CNT_W'({1'b0, ackn_q[14:0]} + 16'd1);
			if (ctl.tick)
				now_q <= now_q + 32'd1;
			if (ctl.timer_stop)
				running_q <= 1'b0;
			if (ctl.time_load) begin
				deadline_q <= trd_q + {16'd0, timeout_q};
				running_q  <= 1'b1;
			end
			if (ctl.launch && go) begin
				cur_q  <= next_q;
				end_q  <= lim;
				retx_q <= 1'b0;
				next_q <= lim;
				if (next_q == base_q) begin
					deadline_q <= now_q + {16'd0, timeout_q};
					running_q  <= 1'b1;
				end
			end
			if (ctl.retx_start) begin
				cur_q      <= base_q;
				end_q      <= next_q;
				retx_q     <= 1'b1;
				deadline_q <= now_q + {16'd0, timeout_q};
				running_q  <= 1'b1;
			end
			if (ctl.advance)
				cur_q <= cur_q + CNT_W'(1);
		end
	end

	always_comb begin
		logic [15:0] cks;
		cks = {{(16-SUM_W){rd_q[MEM_W-1]}}, rd_q[MEM_W-1:PL_W]} + 16'(cur_q) + 16'd1;
		out_data = {6'd0, rd_q[PL_W-1:0], cks, 10'(cur_q)};
		out_retx = retx_q;
		out_last = stat.emit_last;
	end

endmodule

// ===== design/gbn_ctrl.sv =====
// Controller state machine of the go-back-n sender. It sequences each item
// and drives the datapath by commands. Depends on gbn_pkg.
module gbn_ctrl
	import gbn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output ctl_t  ctl
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch_in = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_IDLE;
				case (stat.cmd)
					CMD_MSG: begin
						if (!stat.full) begin
							ctl.msg_write = 1'b1;
							ctl.launch = 1'b1;
							ctl.single = 1'b1;
							if (stat.msg_go)
								state_d = ST_RD;
						end
					end
					CMD_ACK: begin
						if (stat.ack_ok) begin
							ctl.ack_update = 1'b1;
							state_d = ST_ACK2;
						end
					end
					CMD_TICK: begin
						ctl.tick = 1'b1;
						state_d = ST_EXPIRE;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_ACK2: begin
				if (stat.base_eq_next) begin
					ctl.timer_stop = 1'b1;
					ctl.launch = 1'b1;
					state_d = stat.launch_go ? ST_RD : ST_IDLE;
				end else begin
					ctl.time_read = 1'b1;
					state_d = ST_TIME;
				end
			end
			ST_TIME: begin
				ctl.time_load = 1'b1;
				ctl.launch = 1'b1;
				state_d = stat.launch_go ? ST_RD : ST_IDLE;
			end
			ST_EXPIRE: begin
				state_d = ST_IDLE;
				if (stat.expire) begin
					if (stat.win_empty) begin
						ctl.timer_stop = 1'b1;
					end else begin
						ctl.retx_start = 1'b1;
						state_d = ST_RD;
					end
				end
			end
			ST_RD: begin
				ctl.rd_issue = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.emit_last) begin
						state_d = ST_IDLE;
					end else begin
						ctl.advance = 1'b1;
						state_d = ST_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule
